// ===== rtl/core/sdk_pkg.sv =====
// sdk_pkg: shared types, constants and tables of the seed-to-key block.
// Holds the AES S-box, the fixed AES-256 round keys and the FNV constants.
// No dependencies.
package sdk_pkg;

  localparam int NumRounds = 14;

  localparam logic [7:0] MODE_AES = 8'd2;
  localparam logic [7:0] MODE_FNV = 8'd3;

  typedef enum logic [1:0] {
    KIND_AES,
    KIND_FNV,
    KIND_ONES
  } kind_t;

  typedef logic [15:0][7:0] aes_blk_t;
  typedef aes_blk_t [NumRounds:0] rk_t;

  // Payload passed from cell to cell
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] seed;
    aes_blk_t    st;
    logic [63:0] h;
  } cell_t;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] MASK_TEXT = 64'h4472697665736563;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] AES_KEY [32] = '{
    8'h62,8'h5d,8'h04,8'h57,8'hab,8'haa,8'h22,8'h99,8'ha5,8'hb9,8'h9b,8'h64,8'hdb,8'h8e,8'h77,8'h38,
    8'h03,8'ha2,8'hc6,8'h79,8'h83,8'hc2,8'h4a,8'h36,8'h4a,8'h35,8'hb6,8'h96,8'ha9,8'h5b,8'hb5,8'h1b
  };

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Key expansion, evaluated at elaboration only
  function automatic rk_t expand_key();
    logic [7:0] s [240];
    logic [7:0] t [4];
    logic [7:0] f;
    logic [7:0] rc;
    rk_t        r;
    rc = 8'h01;
    for (int i = 0; i < 32; i++) s[i] = AES_KEY[i];
    for (int w = 8; w < 60; w++) begin
      for (int k = 0; k < 4; k++) t[k] = s[(w - 1) * 4 + k];
      if ((w % 8) == 0) begin
        f    = t[0];
        t[0] = SBOX[t[1]] ^ rc;
        t[1] = SBOX[t[2]];
        t[2] = SBOX[t[3]];
        t[3] = SBOX[f];
        rc   = gf_double(rc);
      end else if ((w % 8) == 4) begin
        for (int k = 0; k < 4; k++) t[k] = SBOX[t[k]];
      end
      for (int k = 0; k < 4; k++) s[w * 4 + k] = s[(w - 8) * 4 + k] ^ t[k];
    end
    for (int n = 0; n <= NumRounds; n++) begin
      for (int p = 0; p < 16; p++) r[n][p] = s[n * 16 + p];
    end
    return r;
  endfunction

  localparam rk_t ROUND_KEYS = expand_key();

endpackage

// ===== rtl/core/sdk_round_cell.sv =====
// sdk_round_cell: one cell of the chain; one AES round and, in the first
// eight cells, one FNV-1a step. Depends on sdk_pkg.
module sdk_round_cell #(
  parameter int ROUND = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sdk_pkg::cell_t cin,
  output sdk_pkg::cell_t cout
);
  import sdk_pkg::*;

  // byte position of this cell's FNV input within seed, counted from bit 0
  localparam int FbPos = (ROUND <= 4) ? (4 - ROUND) : ((ROUND - 5) % 4);

  aes_blk_t    sub;
  aes_blk_t    mix;
  logic [7:0]  fbyte;
  logic [63:0] hx;
  logic [63:0] h_next;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sub[r + 4 * c] = SBOX[cin.st[r + 4 * ((c + r) % 4)]];
      end
    end
    mix = sub;
    if (ROUND != NumRounds) begin
      for (int c = 0; c < 4; c++) begin
        logic [7:0] all;
        all = sub[4*c] ^ sub[4*c+1] ^ sub[4*c+2] ^ sub[4*c+3];
        mix[4*c]   = sub[4*c]   ^ all ^ gf_double(sub[4*c]   ^ sub[4*c+1]);
        mix[4*c+1] = sub[4*c+1] ^ all ^ gf_double(sub[4*c+1] ^ sub[4*c+2]);
        mix[4*c+2] = sub[4*c+2] ^ all ^ gf_double(sub[4*c+2] ^ sub[4*c+3]);
        mix[4*c+3] = sub[4*c+3] ^ all ^ gf_double(sub[4*c+3] ^ sub[4*c]);
      end
    end
  end

  // Seed bytes 0..3 then 3..0; byte 0 sits in seed[31:24]
  always_comb begin
    fbyte = cin.seed[8 * FbPos +: 8];
    hx = cin.h ^ {56'd0, fbyte};
    // times 0x100000001b3 as shift-adds
    h_next = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) + (hx << 1) + hx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (en) begin
      cout.valid <= cin.valid;
    end
    if (en) begin
      cout.kind <= cin.kind;
      cout.seed <= cin.seed;
      cout.st   <= mix ^ ROUND_KEYS[ROUND];
      cout.h    <= (ROUND <= 8) ? h_next : cin.h;
    end
  end

endmodule

// ===== rtl/core/seed_to_key_derivation_top.sv =====
// seed_to_key_derivation_top: seed to 64-bit key, AES-256 or FNV-1a by mode, else all ones.
// Depends on sdk_pkg and sdk_round_cell.
//
// channel   | dir | width | contents
// s_axis    | in  | 32    | seed_word
// m_axis    | out | 64    | derived_key
// cfg       | in  | 8     | session_mode, write enable only
//
// 16 register stages: input register, 14 round cells, output register.
// One item per cycle while the chain does not stall; every cell advances together.
// The chain stalls as a whole while a result waits on m_tready.
// rst is synchronous; it clears valid bits and sets session_mode to 3.
module seed_to_key_derivation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // session_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // [31:0] seed_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata        // [63:0] derived_key
);
  import sdk_pkg::*;

  logic       en;
  logic [7:0] session_mode;
  cell_t      chain [NumRounds + 1];
  aes_blk_t   blk_in;
  kind_t      kind_in;
  logic [63:0] key_next;

  // whole chain moves unless the output holds an untaken result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_mode <= MODE_FNV;
    end else if (cfg_we) begin
      session_mode <= cfg_wdata;
    end
  end

  always_comb begin
    blk_in = '0;
    blk_in[0] = s_tdata[31:24];
    blk_in[1] = s_tdata[23:16];
    blk_in[2] = s_tdata[15:8];
    blk_in[3] = s_tdata[7:0];
    unique case (session_mode)
      MODE_AES: kind_in = KIND_AES;
      MODE_FNV: kind_in = KIND_FNV;
      default:  kind_in = KIND_ONES;
    endcase
  end

  // input register: initial AddRoundKey, FNV offset basis
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= s_tvalid;
    end
    if (en) begin
      chain[0].kind <= kind_in;
      chain[0].seed <= s_tdata;
      chain[0].st   <= blk_in ^ ROUND_KEYS[0];
      chain[0].h    <= FNV_BASIS;
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_cell
    sdk_round_cell #(.ROUND(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .cin  (chain[g - 1]),
      .cout (chain[g])
    );
  end

  // key selection from the last cell
  always_comb begin
    case (chain[NumRounds].kind)
      KIND_AES: key_next = {chain[NumRounds].st[0],  chain[NumRounds].st[1],
                            chain[NumRounds].st[2],  chain[NumRounds].st[3],
                            chain[NumRounds].st[12], chain[NumRounds].st[13],
                            chain[NumRounds].st[14], chain[NumRounds].st[15]};
      KIND_FNV: key_next = chain[NumRounds].h ^ MASK_TEXT;
      default:  key_next = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain[NumRounds].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= key_next;
    end
  end

endmodule

// ===== rtl/core/sdk_checker.sv =====
// sdk_checker: port-level assertions for seed_to_key_derivation_top.
// Bound to the top level below; no package use.
module sdk_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind seed_to_key_derivation_top sdk_checker u_sdk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
